// ----- design/ntl_pkg.sv -----
// Shared constants, codes and types for the nearest-time table lookup block.
// Depends on nothing; every other design file refers to it by scoped names.
package ntl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int DIST_W      = 32;
    localparam int ACT_W       = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [TIME_W-1:0] wr_time;
        logic [DIST_W-1:0] wr_dist;
    } mem_wr_t;

endpackage

// ----- design/nearest_time_table_lookup_unit.sv -----
// Top level of the nearest-time table lookup: handshakes, search sequencer, result register.
// Depends on ntl_pkg, ntl_table and ntl_gap.
//
// Channel   Dir  tdata (low bit up)                      tuser
// s_axis    in   time_value[31:0], distance_value[31:0]  action[1:0]
// m_axis    out  found_distance[31:0]                    table_empty
//
// A query on a non-empty table runs S search steps (about log2 of the fill count less one,
// 9 for a full table): each step reads the left and right times through the single table
// read port and runs them through the one gap unit, then decides.
// aresetn empties the table; stored entries are not cleared. s_axis_tready is low for the
// whole of a query, including while its result waits for the previous result to be taken.
module nearest_time_table_lookup_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // time_value, distance_value
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // found_distance
    output logic [0:0]  m_axis_tuser    // table_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTR,
        S_LEFT_C,
        S_LEFT,
        S_RIGHT,
        S_DECIDE,
        S_DIST,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [ntl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ntl_pkg::IDX_W-1:0]  centre_reg, centre_next;
    logic [ntl_pkg::IDX_W-1:0]  step_reg, step_next;
    logic [ntl_pkg::TIME_W-1:0] query_reg, query_next;
    logic [ntl_pkg::TIME_W-1:0] dc_reg, dc_next;
    logic [ntl_pkg::TIME_W-1:0] dl_reg, dl_next;
    logic [ntl_pkg::DIST_W-1:0] res_dist_reg, res_dist_next;
    logic                       res_empty_reg, res_empty_next;
    logic                       m_valid_reg, m_valid_next;
    logic [ntl_pkg::DIST_W-1:0] m_data_reg, m_data_next;
    logic                       m_empty_reg, m_empty_next;

    ntl_pkg::mem_wr_t           wr;
    logic [ntl_pkg::IDX_W-1:0]  rd_addr;
    logic [ntl_pkg::TIME_W-1:0] rd_time;
    logic [ntl_pkg::DIST_W-1:0] rd_dist;
    logic [ntl_pkg::TIME_W-1:0] gap;

    logic [ntl_pkg::IDX_W-1:0]  last_idx;
    logic [ntl_pkg::IDX_W-1:0]  left_idx;
    logic [ntl_pkg::IDX_W-1:0]  right_idx;
    logic [ntl_pkg::IDX_W-1:0]  sel_idx;
    logic                       go_left;
    logic                       go_right;
    logic                       s_accept;
    logic [ntl_pkg::ACT_W-1:0]  s_action;
    logic [ntl_pkg::TIME_W-1:0] s_time;
    logic [ntl_pkg::DIST_W-1:0] s_dist;

    ntl_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_dist (rd_dist)
    );

    ntl_gap u_gap (
        .time_a (rd_time),
        .time_b (query_reg),
        .gap    (gap)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_action      = s_axis_tuser;
    assign s_time        = s_axis_tdata[ntl_pkg::TIME_W-1:0];
    assign s_dist        = s_axis_tdata[ntl_pkg::TIME_W +: ntl_pkg::DIST_W];

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_empty_reg;

    assign last_idx  = ntl_pkg::IDX_W'(count_reg - 1'b1);
    assign left_idx  = (centre_reg >= step_reg) ? (centre_reg - step_reg) : '0;
    assign right_idx = (step_reg <= (last_idx - centre_reg)) ? (centre_reg + step_reg)
                                                             : last_idx;

    // gap holds the right-hand distance while in S_DECIDE
    assign go_left  = (dl_reg < gap) && (dl_reg < dc_reg);
    assign go_right = (gap < dl_reg) && (gap < dc_reg);
    assign sel_idx  = go_left ? left_idx : (go_right ? right_idx : centre_reg);

    always_comb begin
        wr.wr_en   = s_accept && (s_action == ntl_pkg::ACT_APPEND)
                     && (count_reg < ntl_pkg::CNT_W'(ntl_pkg::TABLE_DEPTH));
        wr.wr_addr = count_reg[ntl_pkg::IDX_W-1:0];
        wr.wr_time = s_time;
        wr.wr_dist = s_dist;
    end

    always_comb begin
        case (state_reg)
            S_CTR:    rd_addr = centre_reg;
            S_LEFT_C: rd_addr = left_idx;
            S_LEFT:   rd_addr = left_idx;
            S_RIGHT:  rd_addr = right_idx;
            S_DECIDE: rd_addr = sel_idx;
            default:  rd_addr = centre_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        centre_next    = centre_reg;
        step_next      = step_reg;
        query_next     = query_reg;
        dc_next        = dc_reg;
        dl_next        = dl_reg;
        res_dist_next  = res_dist_reg;
        res_empty_next = res_empty_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_empty_next   = m_empty_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (s_action)
                        ntl_pkg::ACT_CLEAR: begin
                            count_next = '0;
                        end
                        ntl_pkg::ACT_APPEND: begin
                            if (wr.wr_en) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ntl_pkg::ACT_QUERY: begin
                            query_next  = s_time;
                            centre_next = ntl_pkg::IDX_W'(count_reg >> 1);
                            step_next   = ntl_pkg::IDX_W'(count_reg >> 2);
                            if (count_reg == '0) begin
                                res_dist_next  = '0;
                                res_empty_next = 1'b1;
                                state_next     = S_EMIT;
                            end else begin
                                state_next = S_CTR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CTR: begin
                state_next = S_LEFT_C;
            end
            S_LEFT_C: begin
                dc_next    = gap;
                state_next = S_RIGHT;
            end
            S_LEFT: begin
                state_next = S_RIGHT;
            end
            S_RIGHT: begin
                dl_next    = gap;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (step_reg <= ntl_pkg::IDX_W'(1)) begin
                    state_next = S_DIST;
                end else begin
                    state_next = S_LEFT;
                    if (go_left) begin
                        centre_next = left_idx;
                        dc_next     = dl_reg;
                        step_next   = ntl_pkg::IDX_W'(({1'b0, step_reg} + 1'b1) >> 1);
                    end else if (go_right) begin
                        centre_next = right_idx;
                        dc_next     = gap;
                        step_next   = ntl_pkg::IDX_W'(({1'b0, step_reg} + 1'b1) >> 1);
                    end else begin
                        step_next = step_reg >> 1;
                    end
                end
            end
            S_DIST: begin
                res_dist_next  = rd_dist;
                res_empty_next = 1'b0;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_dist_reg;
                    m_empty_next = res_empty_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        centre_reg    <= centre_next;
        step_reg      <= step_next;
        query_reg     <= query_next;
        dc_reg        <= dc_next;
        dl_reg        <= dl_next;
        res_dist_reg  <= res_dist_next;
        res_empty_reg <= res_empty_next;
        m_data_reg    <= m_data_next;
        m_empty_reg   <= m_empty_next;
    end

endmodule

// ----- design/ntl_table.sv -----
// Time and distance storage: one write port, one shared read address, registered reads.
// Depends on ntl_pkg.
module ntl_table (
    input  logic                          aclk,
    input  ntl_pkg::mem_wr_t              wr,
    input  logic [ntl_pkg::IDX_W-1:0]     rd_addr,
    output logic [ntl_pkg::TIME_W-1:0]    rd_time,
    output logic [ntl_pkg::DIST_W-1:0]    rd_dist
);

    logic [ntl_pkg::TIME_W-1:0] time_mem [ntl_pkg::TABLE_DEPTH];
    logic [ntl_pkg::DIST_W-1:0] dist_mem [ntl_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            time_mem[wr.wr_addr] <= wr.wr_time;
            dist_mem[wr.wr_addr] <= wr.wr_dist;
        end
        rd_time <= time_mem[rd_addr];
        rd_dist <= dist_mem[rd_addr];
    end

endmodule

// ----- design/ntl_gap.sv -----
// Shared absolute-difference unit between a stored time and the query time.
// Depends on ntl_pkg.
module ntl_gap (
    input  logic [ntl_pkg::TIME_W-1:0] time_a,
    input  logic [ntl_pkg::TIME_W-1:0] time_b,
    output logic [ntl_pkg::TIME_W-1:0] gap
);

    assign gap = (time_a >= time_b) ? (time_a - time_b) : (time_b - time_a);

endmodule

// ----- bench/nearest_time_lookup_checker.sv -----
// Result checker for the nearest-time table lookup: mirrors the time/distance table,
// predicts each query answer and compares it with the words on the result channel.
// Depends on ntl_pkg for widths, table depth and action codes.
`timescale 1ns / 1ps

module nearest_time_lookup_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // time_value, distance_value
    input  logic [1:0]  s_axis_tuser,   // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // found_distance
    input  logic [0:0]  m_axis_tuser,   // table_empty
    output int          fail_count,
    output int          pending
);
    import ntl_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] found_distance;
        logic              table_empty;
    } lookup_result_t;

    logic [TIME_W-1:0] time_tab [TABLE_DEPTH];
    logic [DIST_W-1:0] dist_tab [TABLE_DEPTH];
    int unsigned       fill;
    lookup_result_t    lookups_due [$];
    lookup_result_t    want;

    function automatic logic [TIME_W-1:0] time_gap(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic int unsigned find_nearest(input logic [TIME_W-1:0] q);
        int unsigned       last, ctr, stp, lft, rgt, pick;
        logic [TIME_W-1:0] dl, dr, dc;
        logic              go_l, go_r, done;
        last = fill - 1;
        ctr  = fill / 2;
        stp  = fill / 4;
        pick = 0;
        done = 1'b0;
        if (ctr > last) ctr = last;
        while (!done) begin
            lft  = (ctr >= stp) ? ctr - stp : 0;
            rgt  = (stp <= last - ctr) ? ctr + stp : last;
            dl   = time_gap(time_tab[lft], q);
            dr   = time_gap(time_tab[rgt], q);
            dc   = time_gap(time_tab[ctr], q);
            go_l = (dl < dr) && (dl < dc);
            go_r = (dr < dl) && (dr < dc);
            if (stp <= 1) begin
                pick = go_l ? lft : (go_r ? rgt : ctr);
                done = 1'b1;
            end else if (go_l) begin
                ctr = lft;
                stp = (stp + 1) / 2;
            end else if (go_r) begin
                ctr = rgt;
                stp = (stp + 1) / 2;
            end else begin
                stp = stp / 2;
            end
        end
        return pick;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [TIME_W-1:0] q);
        lookup_result_t r;
        if (fill == 0) begin
            r.found_distance = '0;
            r.table_empty    = 1'b1;
        end else begin
            r.found_distance = dist_tab[find_nearest(q)];
            r.table_empty    = 1'b0;
        end
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        fill       = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            lookups_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t: result word with none expected, actual distance %h empty %b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    fail_count++;
                end else begin
                    want = lookups_due.pop_front();
                    if (m_axis_tdata !== want.found_distance) begin
                        $display("%0t: found_distance expected %h actual %h",
                                 $time, want.found_distance, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.table_empty) begin
                        $display("%0t: table_empty expected %b actual %b",
                                 $time, want.table_empty, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    ACT_CLEAR: fill = 0;
                    ACT_APPEND: begin
                        if (fill < TABLE_DEPTH) begin
                            time_tab[fill] = s_axis_tdata[31:0];
                            dist_tab[fill] = s_axis_tdata[63:32];
                            fill = fill + 1;
                        end
                    end
                    ACT_QUERY: lookups_due.push_back(predict_lookup(s_axis_tdata[31:0]));
                    default: ;
                endcase
            end
        end
        pending <= lookups_due.size();
    end

endmodule

// ----- bench/nearest_time_table_lookup_unit_tb.sv -----
// Testbench top for nearest_time_table_lookup_unit: clock, reset, stimulus and verdict.
// Depends on ntl_pkg, the block and nearest_time_lookup_checker.
`timescale 1ns / 1ps

module nearest_time_table_lookup_unit_tb;
    import ntl_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NOP     = 2'd3;
    localparam int               CYCLE_LIMIT = 1000000;
    localparam int               WORD_GOAL   = 1950;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // time_value, distance_value
    logic [1:0]  s_axis_tuser  = '0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // found_distance
    logic [0:0]  m_axis_tuser;         // table_empty

    int          fail_count;
    int          pending;
    int unsigned cycles       = 0;
    int unsigned words_sent   = 0;
    int unsigned tx_idle      = 22;
    int unsigned rx_idle      = 47;
    int unsigned results_seen = 0;
    int unsigned hold_left    = 0;
    bit          held         = 1'b0;
    logic [31:0] table_times [$];

    nearest_time_table_lookup_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nearest_time_lookup_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold off the result channel once for a long stretch
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held && results_seen == 30) begin
            held          <= 1'b1;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [31:0] tv,
                             input logic [31:0] dv);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dv, tv};
        s_axis_tuser  <= act;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        case (act)
            ACT_CLEAR: begin
                table_times.delete();
                words_sent++;
            end
            ACT_APPEND: begin
                if (table_times.size() < TABLE_DEPTH) begin
                    table_times.push_back(tv);
                    words_sent++;
                end
            end
            ACT_QUERY: words_sent++;
            default: ;
        endcase
        if (words_sent == 450) begin
            tx_idle = 47;
            rx_idle = 22;
        end else if (words_sent == 900) begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    function automatic logic [31:0] pick_query_time();
        int unsigned k;
        logic [31:0] a, b, q;
        logic [32:0] sum;
        k = $urandom_range(9);
        q = $urandom;
        if (table_times.size() != 0 && k < 6) begin
            a = table_times[$urandom_range(table_times.size() - 1)];
            b = table_times[$urandom_range(table_times.size() - 1)];
            sum = {1'b0, a} + {1'b0, b};
            if (k < 3) q = a;
            else if (k < 5) q = a + $urandom_range(32'h1_FFFF) - 32'h1_0000;
            else q = sum[32:1];
        end else if (k == 8) begin
            q = 32'h0000_0000;
        end else if (k == 9) begin
            q = 32'hFFFF_FFFF;
        end
        return q;
    endfunction

    task automatic query_near();
        send_word(ACT_QUERY, pick_query_time(), $urandom);
    endtask

    task automatic fill_table(input int unsigned n, input bit ordered);
        logic [31:0] t;
        logic [31:0] span;
        t    = $urandom_range(32'h0100_0000);
        span = 32'd1 << $urandom_range(4, 18);
        repeat (n) begin
            if (ordered) t = t + $urandom_range(span);
            else t = $urandom;
            send_word(ACT_APPEND, t, $urandom);
        end
    endtask

    initial begin
        int unsigned roll;
        bit          full_done;
        full_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, unused code, one to six entries, extremes, ties
        send_word(ACT_QUERY,  32'h1234_5678, $urandom);
        send_word(ACT_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, 32'h0000_0000, 32'h8000_0000);
        send_word(ACT_QUERY,  32'h1234_5678, 32'h0);
        send_word(ACT_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_word(ACT_QUERY,  32'hFFFF_FFF0, 32'h0);
        send_word(ACT_QUERY,  32'h0000_0000, 32'h0);
        send_word(ACT_APPEND, 32'h0001_0000, 32'd5);
        send_word(ACT_QUERY,  32'h0000_0001, 32'h0);
        send_word(ACT_APPEND, 32'h0002_0000, -32'sd5);
        send_word(ACT_QUERY,  32'h0001_8000, 32'h0);
        send_word(ACT_QUERY,  32'h0002_0000, 32'h0);
        send_word(ACT_QUERY,  32'hFFFF_FFFE, 32'h0);
        send_word(ACT_APPEND, 32'h0002_0000, 32'd77);
        send_word(ACT_APPEND, 32'h0002_0000, 32'd78);
        send_word(ACT_QUERY,  32'h0002_0000, 32'h0);
        send_word(ACT_QUERY,  32'h8000_0000, 32'h0);
        send_word(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_QUERY,  32'h0000_0000, 32'h0);
        send_word(ACT_APPEND, 32'h0003_0000, 32'd1);
        send_word(ACT_QUERY,  32'hFFFF_FFFF, 32'h0);
        send_word(ACT_CLEAR,  32'h0, 32'h0);

        while (words_sent < WORD_GOAL) begin
            roll = $urandom_range(99);
            if (!full_done && words_sent >= 900) begin
                full_done = 1'b1;
                send_word(ACT_CLEAR, $urandom, $urandom);
                fill_table(TABLE_DEPTH + 6, 1'b1);
                repeat (12) query_near();
            end else if (roll < 70) begin
                send_word(ACT_CLEAR, $urandom, $urandom);
                if ($urandom_range(99) < 85) fill_table($urandom_range(1, 24),
                                                        $urandom_range(99) < 75);
                else fill_table($urandom_range(25, 200), $urandom_range(99) < 75);
                repeat ($urandom_range(2, 10)) query_near();
            end else if (roll < 85) begin
                fill_table($urandom_range(1, 8), 1'b0);
                repeat ($urandom_range(1, 4)) query_near();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(ACT_W'($urandom_range(3)), $urandom, $urandom);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
